// ----- hdl/siq_pkg.sv -----
// Shared types and codes for the sorted insertion priority queue.
// No dependencies; imported by the cell, the top level and the checker.
package siq_pkg;

  // One stored entry: id in the high half, then destination, then origin.
  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  dest;
    logic [7:0]  orig;
  } entry_t;

  // Sort key: destination first, origin second.
  typedef logic [15:0] key_t;

  // Operation broadcast to every cell in a cycle.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

  // Request kinds.
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Error codes reported with every result.
  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_POP_EMPTY = 2'd1,
    ERR_PUSH_FULL = 2'd2
  } err_t;

  function automatic key_t key_of(entry_t e);
    key_of = {e.dest, e.orig};
  endfunction

endpackage

// ----- hdl/sorted_insert_priority_queue_unit.sv -----
// The result of a request is presented in the cycle after it is accepted.
// One push or pop per cycle while the output is not stalled; every cell compares
// against the new key at once and shifts by one place, and a registered output
// stage takes the result. Reset clears the cell valid bits, the entry count and
// the output valid bit at once. Depends on siq_pkg and siq_cell.
module sorted_insert_priority_queue_unit
  import siq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: entry_id[15:0], dest_station[23:16], orig_station[31:24]
  input  logic [31:0] s_axis_tdata,
  // tuser: kind[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: front_valid[0], front_id[16:1], front_dest[24:17], front_orig[32:25],
  //        occupancy[37:33], error_code[39:38]
  output logic [39:0] m_axis_tdata
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic          accept;
  logic          kind;
  entry_t        new_entry;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          empty;
  logic          full;
  cell_ctrl_t    ctrl;
  err_t          err;

  logic   cell_valid [QUEUE_DEPTH];
  entry_t cell_entry [QUEUE_DEPTH];
  logic   cell_ins   [QUEUE_DEPTH];
  logic   cell_vnext [QUEUE_DEPTH];
  entry_t cell_enext [QUEUE_DEPTH];

  // Request decode.
  assign s_axis_tready  = !m_axis_tvalid || m_axis_tready;
  assign accept         = s_axis_tvalid && s_axis_tready;
  assign kind           = s_axis_tuser;
  assign new_entry.id   = s_axis_tdata[15:0];
  assign new_entry.dest = s_axis_tdata[23:16];
  assign new_entry.orig = s_axis_tdata[31:24];

  assign empty = (count == '0);
  assign full  = (count == CW'(QUEUE_DEPTH));

  // Drop a pop on empty and a push on full; flag either.
  always_comb begin
    ctrl       = '0;
    err        = ERR_NONE;
    count_next = count;
    if (accept) begin
      if (kind == KIND_PUSH) begin
        if (full) begin
          err = ERR_PUSH_FULL;
        end else begin
          ctrl.push  = 1'b1;
          count_next = count + 1'b1;
        end
      end else begin
        if (empty) begin
          err = ERR_POP_EMPTY;
        end else begin
          ctrl.pop   = 1'b1;
          count_next = count - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Row of cells, each linked to its left and right neighbors.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   p_valid;
    entry_t p_entry;
    logic   p_ins;
    logic   n_valid;
    entry_t n_entry;

    if (i == 0) begin : g_first
      assign p_valid = 1'b0;
      assign p_entry = '0;
      assign p_ins   = 1'b0;
    end else begin : g_mid
      assign p_valid = cell_valid[i-1];
      assign p_entry = cell_entry[i-1];
      assign p_ins   = cell_ins[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign n_valid = 1'b0;
      assign n_entry = '0;
    end else begin : g_inner
      assign n_valid = cell_valid[i+1];
      assign n_entry = cell_entry[i+1];
    end

    siq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_entry  (new_entry),
      .prev_valid (p_valid),
      .prev_entry (p_entry),
      .prev_ins   (p_ins),
      .next_valid (n_valid),
      .next_entry (n_entry),
      .valid      (cell_valid[i]),
      .entry      (cell_entry[i]),
      .ins        (cell_ins[i]),
      .valid_next (cell_vnext[i]),
      .entry_next (cell_enext[i])
    );
  end

  // Output stage: front entry after the step, count and error code.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Front fields go out id first, then destination, then origin.
  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata[0]     <= cell_vnext[0];
      m_axis_tdata[16:1]  <= cell_vnext[0] ? cell_enext[0].id : '0;
      m_axis_tdata[24:17] <= cell_vnext[0] ? cell_enext[0].dest : '0;
      m_axis_tdata[32:25] <= cell_vnext[0] ? cell_enext[0].orig : '0;
      m_axis_tdata[37:33] <= 5'(count_next);
      m_axis_tdata[39:38] <= err;
    end
  end

endmodule

// ----- hdl/siq_cell.sv -----
// One slot of the sorted queue: holds an entry and its valid bit.
// Depends on siq_pkg; instantiated in a row by the top level.
module siq_cell
  import siq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  entry_t     new_entry,
  input  logic       prev_valid,
  input  entry_t     prev_entry,
  input  logic       prev_ins,
  input  logic       next_valid,
  input  entry_t     next_entry,
  output logic       valid,
  output entry_t     entry,
  output logic       ins,
  output logic       valid_next,
  output entry_t     entry_next
);

  // The new entry belongs at or before this slot when the slot is empty or
  // holds a strictly larger key, which keeps equal keys in arrival order.
  assign ins = !valid || (key_of(entry) > key_of(new_entry));

  // Push: slots past the insert point take their left neighbor, the insert
  // point takes the new entry. Pop: every slot takes its right neighbor.
  always_comb begin
    valid_next = valid;
    entry_next = entry;
    if (ctrl.push) begin
      if (prev_ins) begin
        valid_next = prev_valid;
        entry_next = prev_entry;
      end else if (ins) begin
        valid_next = 1'b1;
        entry_next = new_entry;
      end
    end else if (ctrl.pop) begin
      valid_next = next_valid;
      entry_next = next_entry;
    end
  end

  // Valid bit is control state; the entry itself needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ----- hdl/siq_checker.sv -----
// Port-level checks for the sorted insertion priority queue.
// Depends on siq_pkg; bound to sorted_insert_priority_queue_unit below.
module siq_checker
  import siq_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Front is reported valid exactly when the queue holds entries.
  a_front: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[37:33] != 5'd0)))
    else $error("front_valid disagrees with occupancy");

  // A pop that found the queue empty leaves it empty.
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[39:38] == ERR_POP_EMPTY)
      |-> (m_axis_tdata[37:33] == 5'd0) && !m_axis_tdata[0])
    else $error("pop-from-empty with entries present");

  // An accepted request always yields a result on the next cycle.
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted request produced no result");

  // Only defined error codes appear.
  a_err: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[39:38] == ERR_NONE) ||
      (m_axis_tdata[39:38] == ERR_POP_EMPTY) || (m_axis_tdata[39:38] == ERR_PUSH_FULL))
    else $error("undefined error code");

endmodule

bind sorted_insert_priority_queue_unit siq_checker u_siq_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
